// ===== rtl/serial_command_frame_parser_defines.svh =====
// Assertion macros for the file that checks internal behavior.
`ifndef SERIAL_COMMAND_FRAME_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCFP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/scfp_pkg.sv =====
package scfp_pkg;

   localparam int FRAME_MAX   = 32;
   localparam int BYTE_W      = 8;
   localparam int IDX_W       = $clog2(FRAME_MAX);
   localparam int PHASE_W     = $clog2(FRAME_MAX + 1);
   // Two payload banks, one per queue slot.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RAM_DEPTH   = QUEUE_DEPTH * FRAME_MAX;
   localparam int RAM_AW      = $clog2(RAM_DEPTH);

   localparam logic [BYTE_W-1:0] START_BYTE_RESET  = 8'h53;
   localparam logic [BYTE_W-1:0] MAX_COMMAND_RESET = 8'h10;

   localparam logic CSR_START_BYTE  = 1'b0;
   localparam logic CSR_MAX_COMMAND = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [IDX_W-1:0]  count;
   } desc_type;

endpackage

// ===== rtl/scfp_ram.sv =====
module scfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/scfp_front.sv =====
module scfp_front
   import scfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic [BYTE_W-1:0] start_byte,
   input  logic [BYTE_W-1:0] max_command,
   input  logic              queue_full,
   output logic              push,
   output desc_type          push_desc,
   output logic              ram_we,
   output logic [RAM_AW-1:0] ram_waddr,
   output logic [BYTE_W-1:0] ram_wdata
);

   localparam logic [PHASE_W-1:0] P_IDLE = PHASE_W'(0);
   localparam logic [PHASE_W-1:0] P_LEN  = PHASE_W'(1);
   localparam logic [PHASE_W-1:0] P_CMD  = PHASE_W'(2);
   localparam logic [PHASE_W-1:0] P_BODY = PHASE_W'(3);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [PHASE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0]  cmd_ff, cmd_in;
   logic               bank_ff, bank_in;
   logic               accept;
   logic [PHASE_W-1:0] body_offset;

   // Payload bytes and the checksum both need a free bank in the queue.
   assign req_ready   = !((phase_ff >= P_BODY) && queue_full);
   assign accept      = req_valid && req_ready;
   assign body_offset = phase_ff - P_BODY;
   assign ram_waddr   = {bank_ff, body_offset[IDX_W-1:0]};
   assign ram_wdata   = req_rx_byte;

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      len_in    = len_ff;
      cmd_in    = cmd_ff;
      bank_in   = bank_ff;
      push      = 1'b0;
      ram_we    = 1'b0;
      push_desc.command = cmd_ff;
      push_desc.count   = IDX_W'(len_ff - P_BODY);
      if (accept) begin
         if (req_mode) begin
            phase_in = P_IDLE;
         end else begin
            case (phase_ff)
               P_IDLE: begin
                  if (req_rx_byte == start_byte) begin
                     phase_in = P_LEN;
                     sum_in   = '0;
                  end
               end
               P_LEN: begin
                  len_in = req_rx_byte[PHASE_W-1:0];
                  sum_in = sum_ff + req_rx_byte;
                  if ((req_rx_byte > BYTE_W'(FRAME_MAX)) || (req_rx_byte < BYTE_W'(3))) begin
                     phase_in = P_IDLE;
                  end else begin
                     phase_in = P_CMD;
                  end
               end
               P_CMD: begin
                  cmd_in = req_rx_byte;
                  sum_in = sum_ff + req_rx_byte;
                  phase_in = (req_rx_byte > max_command) ? P_IDLE : P_BODY;
               end
               default: begin
                  if (phase_ff < len_ff) begin
                     ram_we   = 1'b1;
                     sum_in   = sum_ff + req_rx_byte;
                     phase_in = phase_ff + PHASE_W'(1);
                  end else begin
                     phase_in = P_IDLE;
                     if (sum_ff == req_rx_byte) begin
                        push    = 1'b1;
                        bank_in = !bank_ff;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         sum_ff   <= '0;
         len_ff   <= '0;
         cmd_ff   <= '0;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         len_ff   <= len_in;
         cmd_ff   <= cmd_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

// ===== rtl/scfp_queue.sv =====
module scfp_queue
   import scfp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output desc_type head,
   output logic     empty,
   output logic     full
);

   desc_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/scfp_back.sv =====
module scfp_back
   import scfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  desc_type          head,
   input  logic              empty,
   output logic              pop,
   output logic [RAM_AW-1:0] ram_raddr,
   input  logic [BYTE_W-1:0] ram_rdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_command,
   output logic [IDX_W-1:0]  rsp_payload_length,
   output logic [IDX_W-1:0]  rsp_byte_index,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic              rsp_has_payload,
   output logic              rsp_last
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_READ = 2'd1;
   localparam logic [1:0] B_SHOW = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              bank_ff, bank_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [IDX_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              has_ff, has_in;
   logic              last_ff, last_in;

   // The RAM samples the next index so that data is ready in the read state.
   assign ram_raddr = {bank_ff, idx_in};
   assign rsp_valid = (state_ff == B_SHOW);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      bank_in  = bank_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      data_in  = data_ff;
      has_in   = has_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               if (head.count == '0) begin
                  cmd_in   = head.command;
                  len_in   = '0;
                  pos_in   = '0;
                  data_in  = '0;
                  has_in   = 1'b0;
                  last_in  = 1'b1;
                  state_in = B_SHOW;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            cmd_in   = head.command;
            len_in   = head.count;
            pos_in   = idx_ff;
            data_in  = ram_rdata;
            has_in   = 1'b1;
            last_in  = ((idx_ff + IDX_W'(1)) == head.count);
            state_in = B_SHOW;
         end
         B_SHOW: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  pop      = 1'b1;
                  idx_in   = '0;
                  bank_in  = !bank_ff;
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = B_READ;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         idx_ff   <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         bank_ff  <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      len_ff  <= len_in;
      pos_ff  <= pos_in;
      data_ff <= data_in;
      has_ff  <= has_in;
      last_ff <= last_in;
   end

   assign rsp_command        = cmd_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_byte_index     = pos_ff;
   assign rsp_payload_byte   = data_ff;
   assign rsp_has_payload    = has_ff;
   assign rsp_last           = last_ff;

endmodule

// ===== rtl/serial_command_frame_parser.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    req_mode, req_rx_byte
// rsp_      out        rsp_valid/rsp_ready    command, length, index, byte, flags
// csr_      in         csr_we                 csr_index, csr_wdata
//
// The front takes one byte per cycle while req_ready is high; a valid frame is queued
// when its checksum arrives. Each payload result passes the registered RAM read, then the
// output register; the back idles between frames, and an empty frame skips the read.
// Reset is synchronous; no memory clearing is needed after reset.
// Two frames may wait in the queue; while both banks are held, req_ready drops
// for payload and checksum bytes until the back finishes a frame.
`include "serial_command_frame_parser_defines.svh"

module serial_command_frame_parser
   import scfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_command,
   output logic [IDX_W-1:0]  rsp_payload_length,
   output logic [IDX_W-1:0]  rsp_byte_index,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic              rsp_has_payload,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [BYTE_W-1:0] csr_wdata
);

   logic [BYTE_W-1:0] start_ff, start_in;
   logic [BYTE_W-1:0] max_cmd_ff, max_cmd_in;
   logic              fifo_full, fifo_empty, fifo_push, fifo_pop;
   desc_type          push_desc, head;
   logic              ram_we;
   logic [RAM_AW-1:0] ram_waddr, ram_raddr;
   logic [BYTE_W-1:0] ram_wdata, ram_rdata;

   always_comb begin
      start_in   = start_ff;
      max_cmd_in = max_cmd_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_BYTE:  start_in   = csr_wdata;
            CSR_MAX_COMMAND: max_cmd_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= START_BYTE_RESET;
         max_cmd_ff <= MAX_COMMAND_RESET;
      end else begin
         start_ff   <= start_in;
         max_cmd_ff <= max_cmd_in;
      end
   end

   scfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_rx_byte (req_rx_byte),
      .start_byte  (start_ff),
      .max_command (max_cmd_ff),
      .queue_full  (fifo_full),
      .push        (fifo_push),
      .push_desc   (push_desc),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata)
   );

   scfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_desc (push_desc),
      .pop       (fifo_pop),
      .head      (head),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   scfp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   scfp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .empty              (fifo_empty),
      .pop                (fifo_pop),
      .ram_raddr          (ram_raddr),
      .ram_rdata          (ram_rdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command        (rsp_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_payload    (rsp_has_payload),
      .rsp_last           (rsp_last)
   );

   `SCFP_ASSERT_SAME(a_ready_with_room, clock, reset, !fifo_full, req_ready, "input stalled")
   `SCFP_ASSERT_SAME(a_no_push_when_full, clock, reset, fifo_push, !fifo_full, "push when full")
   `SCFP_ASSERT_SAME(a_result_has_frame, clock, reset, rsp_valid, !fifo_empty, "no frame queued")
   `SCFP_ASSERT_NEXT(a_idle_after_frame, clock, reset, fifo_pop, !rsp_valid, "result after pop")

endmodule
